// File: design/sasc_pkg.sv
// Shared types, constants and helpers for the six-axis step command sequencer.
// Used by the command parser, the axis bank and the top level; no dependencies.
package sasc_pkg;

  // Axis count and step counter width
  localparam int NUM_AXES   = 6;
  localparam int COUNT_BITS = 16;
  localparam int AXIS_W     = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int ACC_W      = 16;

  // Command characters
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE = 8'h39;  // '9'
  localparam logic [7:0] CH_SEP  = 8'h2C;  // ','
  localparam logic [7:0] CH_END  = 8'h5E;  // '^'
  localparam logic [7:0] CH_ARM  = 8'h2A;  // '*'

  // Axis 5 finishing also marks axis 6 done
  localparam int QUIRK_SRC = 4;
  localparam int QUIRK_DST = 5;

  // Request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Command from the parser to the axis bank
  typedef struct packed {
    logic                  load;
    logic [AXIS_W-1:0]     axis;
    logic [COUNT_BITS-1:0] count;
    logic                  dir;
    logic                  arm;
  } axis_cmd_t;

  // Next pin and status values from the axis bank
  typedef struct packed {
    logic [NUM_AXES-1:0] step_pins;
    logic [NUM_AXES-1:0] dir_pins;
    logic [NUM_AXES-1:0] done_mask;
    logic                stop_event;
  } axis_status_t;

  // Append a decimal digit, saturating at the accumulator maximum
  function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W-1:0] acc,
                                               input logic [3:0] d);
    logic [ACC_W+3:0] v;
    v = ({4'b0, acc} * (ACC_W + 4)'(10)) + (ACC_W + 4)'(d);
    if (v[ACC_W+3:ACC_W] != 4'b0) begin
      return '1;
    end
    return v[ACC_W-1:0];
  endfunction

  // Same for the step count field
  function automatic logic [COUNT_BITS-1:0] sat_count(input logic [COUNT_BITS-1:0] acc,
                                                      input logic [3:0] d);
    logic [COUNT_BITS+3:0] v;
    v = ({4'b0, acc} * (COUNT_BITS + 4)'(10)) + (COUNT_BITS + 4)'(d);
    if (v[COUNT_BITS+3:COUNT_BITS] != 4'b0) begin
      return '1;
    end
    return v[COUNT_BITS-1:0];
  endfunction

endpackage

// File: design/sasc_cmd_parser.sv
// ASCII command parser: collects "axis,dir,steps^" and '*' into axis commands.
// Depends on sasc_pkg.
module sasc_cmd_parser import sasc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      byte_en,
  input  logic [7:0] rx_byte,
  output axis_cmd_t cmd
);

  typedef enum logic [1:0] {
    FLD_AXIS    = 2'd0,
    FLD_DIR     = 2'd1,
    FLD_COUNT   = 2'd2,
    FLD_SURPLUS = 2'd3
  } field_t;

  field_t                field_idx_r, field_idx_nxt;
  logic                  field_end_r, field_end_nxt;
  logic [ACC_W-1:0]      axis_acc_r, axis_acc_nxt;
  logic [ACC_W-1:0]      dir_acc_r, dir_acc_nxt;
  logic [COUNT_BITS-1:0] count_acc_r, count_acc_nxt;
  logic                  axis_ok;

  assign axis_ok = (axis_acc_r >= ACC_W'(1)) && (axis_acc_r <= ACC_W'(NUM_AXES));

  // Decode one byte
  always_comb begin
    field_idx_nxt = field_idx_r;
    field_end_nxt = field_end_r;
    axis_acc_nxt  = axis_acc_r;
    dir_acc_nxt   = dir_acc_r;
    count_acc_nxt = count_acc_r;
    cmd           = '0;
    cmd.axis      = AXIS_W'(axis_acc_r - ACC_W'(1));
    cmd.count     = count_acc_r;
    cmd.dir       = (dir_acc_r == ACC_W'(1));
    if (byte_en) begin
      case (rx_byte) inside
        [CH_ZERO:CH_NINE]: begin
          // low nibble of an ASCII digit is its value
          if (!field_end_r) begin
            case (field_idx_r)
              FLD_AXIS:  axis_acc_nxt  = sat_acc(axis_acc_r, rx_byte[3:0]);
              FLD_DIR:   dir_acc_nxt   = sat_acc(dir_acc_r, rx_byte[3:0]);
              FLD_COUNT: count_acc_nxt = sat_count(count_acc_r, rx_byte[3:0]);
              default:   ;
            endcase
          end
        end
        CH_SEP: begin
          case (field_idx_r)
            FLD_AXIS:  field_idx_nxt = FLD_DIR;
            FLD_DIR:   field_idx_nxt = FLD_COUNT;
            default:   field_idx_nxt = FLD_SURPLUS;
          endcase
          field_end_nxt = 1'b0;
        end
        CH_END, CH_ARM: begin
          cmd.load      = (rx_byte == CH_END) && axis_ok;
          cmd.arm       = (rx_byte == CH_ARM);
          field_idx_nxt = FLD_AXIS;
          field_end_nxt = 1'b0;
          axis_acc_nxt  = '0;
          dir_acc_nxt   = '0;
          count_acc_nxt = '0;
        end
        default: field_end_nxt = 1'b1;
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_idx_r <= FLD_AXIS;
      field_end_r <= 1'b0;
      axis_acc_r  <= '0;
      dir_acc_r   <= '0;
      count_acc_r <= '0;
    end else begin
      field_idx_r <= field_idx_nxt;
      field_end_r <= field_end_nxt;
      axis_acc_r  <= axis_acc_nxt;
      dir_acc_r   <= dir_acc_nxt;
      count_acc_r <= count_acc_nxt;
    end
  end

endmodule

// File: design/sasc_axis_bank.sv
// Per-axis step counters, direction, arm, phase and done bits; one tick per item.
// Depends on sasc_pkg.
module sasc_axis_bank import sasc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         tick_en,
  input  axis_cmd_t    cmd,
  output axis_status_t status
);

  logic [COUNT_BITS-1:0] count_r [NUM_AXES];
  logic [COUNT_BITS-1:0] count_nxt [NUM_AXES];
  logic [COUNT_BITS-1:0] dec;
  logic [NUM_AXES-1:0]   dir_r, dir_nxt;
  logic [NUM_AXES-1:0]   armed_r, armed_nxt;
  logic [NUM_AXES-1:0]   phase_r, phase_nxt;
  logic [NUM_AXES-1:0]   fin_r, fin_nxt;
  logic [NUM_AXES-1:0]   fin_hit;
  logic                  stop;

  // Update the addressed lane for a load, and every lane for an arm or a tick
  always_comb begin
    count_nxt = count_r;
    dir_nxt   = dir_r;
    armed_nxt = armed_r;
    phase_nxt = phase_r;
    fin_nxt   = fin_r;
    fin_hit   = '0;
    dec       = '0;
    if (cmd.load) begin
      count_nxt[cmd.axis] = cmd.count;
      dir_nxt[cmd.axis]   = cmd.dir;
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      if (cmd.arm) begin
        if (count_r[i] == '0) begin
          fin_hit[i] = 1'b1;
        end else begin
          armed_nxt[i] = 1'b1;
        end
      end
      if (tick_en && armed_r[i]) begin
        if (phase_r[i]) begin
          // drop the pin and count the step, never below zero
          dec          = count_r[i] - COUNT_BITS'(count_r[i] != '0);
          phase_nxt[i] = 1'b0;
          count_nxt[i] = dec;
          fin_hit[i]   = (dec == '0);
        end else if (count_r[i] == '0) begin
          fin_hit[i] = 1'b1;
        end else begin
          phase_nxt[i] = 1'b1;
        end
      end
    end
    // Finish: mark done, disarm, drop the pin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (fin_hit[i]) begin
        fin_nxt[i]   = 1'b1;
        armed_nxt[i] = 1'b0;
        phase_nxt[i] = 1'b0;
      end
    end
    if (NUM_AXES > QUIRK_DST) begin
      if (fin_hit[QUIRK_SRC]) begin
        fin_nxt[QUIRK_DST] = 1'b1;
      end
    end
    // All done: raise the stop event and clear the mask
    stop = &fin_nxt;
    if (stop) begin
      fin_nxt = '0;
    end
    status.step_pins  = phase_nxt;
    status.dir_pins   = dir_nxt;
    status.done_mask  = fin_nxt;
    status.stop_event = stop;
  end

  // Hold axis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        count_r[i] <= '0;
      end
      dir_r   <= '1;
      armed_r <= '0;
      phase_r <= '0;
      fin_r   <= '0;
    end else begin
      count_r <= count_nxt;
      dir_r   <= dir_nxt;
      armed_r <= armed_nxt;
      phase_r <= phase_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

// File: design/six_axis_step_command_sequencer.sv
// Six-axis step/direction command sequencer, top level.
// An accepted item passes the input register, then the result register, on its way
// to the out_ port. Throughput: one item per cycle while out_stall is low; the input
// register can take a new item while a result waits.
// Reset (rst_n low, synchronous): parser cleared, counts zero, directions high,
// no axis armed, no done bits, both registers empty.
module six_axis_step_command_sequencer import sasc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [NUM_AXES-1:0] out_step_pins,
  output logic [NUM_AXES-1:0] out_dir_pins,
  output logic [NUM_AXES-1:0] out_done_mask,
  output logic                out_stop_event
);

  logic         s1_valid_r, s1_valid_nxt;
  logic         s1_req_type_r;
  logic [7:0]   s1_rx_byte_r;
  logic         out_valid_r, out_valid_nxt;
  axis_status_t out_r;
  logic         in_take;
  logic         go;
  axis_cmd_t    cmd;
  axis_status_t status;

  // Advance the held item when the result register is free or draining
  assign go       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !go;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !go);
  assign out_valid_nxt = go || (out_valid_r && out_stall);

  sasc_cmd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (go && (s1_req_type_r == REQ_BYTE)),
    .rx_byte (s1_rx_byte_r),
    .cmd     (cmd)
  );

  sasc_axis_bank u_axes (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (go && (s1_req_type_r == REQ_TICK)),
    .cmd     (cmd),
    .status  (status)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_take) begin
      s1_req_type_r <= in_req_type;
      s1_rx_byte_r  <= in_rx_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (go) begin
      out_r <= status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_step_pins  = out_r.step_pins;
  assign out_dir_pins   = out_r.dir_pins;
  assign out_done_mask  = out_r.done_mask;
  assign out_stop_event = out_r.stop_event;

`ifndef NO_ASSERTIONS
  // A stop event always comes with a cleared done mask
  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.stop_event) |-> (out_r.done_mask == '0))
    else $error("stop event with done mask not cleared");

  // A new result appears only from a held input item
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without an input item");

  // Input stalls only while an item waits behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");
`endif

endmodule
